// ===== src/lzrd_pkg.sv =====
// Shared types and constants for the LZSS ring decompressor.
package lzrd_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  // Wide enough for a token distance (up to 4098) and for the ring depth itself
  localparam int unsigned BACK_W     = RING_AW + 1;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned RUN_W      = 5;
  localparam int unsigned FLAG_BITS  = 8;
  localparam int unsigned MATCH_BIAS = 3;

  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_ITEM   = 2'd1,
    PH_TOKEN2 = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LIT  = 2'd1,
    S_RD   = 2'd2,
    S_EMIT = 2'd3
  } state_e;

endpackage

// ===== src/lzss_ring_decompressor.sv =====
// LZSS decompressor top level: stream parser, history ring and copy sequencer.
// Parsing: a flag byte or first token byte is taken with no result; a literal is
// held in S_LIT and registered into the output register once the output is free.
// Copy: one ring read/write port serves the copy, a read (S_RD) then an emit with
// write (S_EMIT) per byte, run 3..18; output stalls hold S_EMIT; input stalls until the item ends.
// Reset: no clearing pass; the ring reads as zero until written, tracked by the
// write index and a wrapped flag. Parser, counters and length register reset to zero.
module lzss_ring_decompressor import lzrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             done_res_o
);

  logic [7:0] ring_mem [RING_DEPTH];

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [7:0]           flags_q, flags_d;
  logic [3:0]           bits_q, bits_d;
  logic [7:0]           th_q, th_d;
  logic [7:0]           lit_q, lit_d;
  logic [RUN_W-1:0]     cnt_q, cnt_d;
  logic [RING_AW-1:0]   src_q, src_d;
  logic [RING_AW-1:0]   ring_idx_q, ring_idx_d;
  logic                 wrapped_q, wrapped_d;
  logic [LEN_W-1:0]     produced_q, produced_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 run_last_q, run_last_d;
  logic                 done_q, done_d;
  logic [7:0]           rd_data_q;
  logic                 hist_ok_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 rd_en;
  logic                 emit_go;
  logic [7:0]           emit_val;
  logic                 emit_last;
  logic                 emit_done;
  logic [LEN_W-1:0]     cnt_next;
  logic [BACK_W-1:0]    dist_w;
  logic [BACK_W-1:0]    back_w;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_next    = produced_q + LEN_W'(1);
  assign emit_done   = (cnt_next >= len_q);

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign done_res_o  = done_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    flags_d     = flags_q;
    bits_d      = bits_q;
    th_d        = th_q;
    lit_d       = lit_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    ring_idx_d  = ring_idx_q;
    wrapped_d   = wrapped_q;
    produced_d  = produced_q;
    len_d       = cfg_we_i ? cfg_wdata_i : len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    done_d      = done_q;
    rd_en       = 1'b0;
    emit_go     = 1'b0;
    emit_val    = lit_q;
    emit_last   = 1'b1;
    dist_w      = BACK_W'({th_q[3:0], in_byte_i}) + BACK_W'(MATCH_BIAS);
    back_w      = (dist_w >= BACK_W'(RING_DEPTH)) ? dist_w - BACK_W'(RING_DEPTH) : dist_w;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (produced_q >= len_q) begin
            // Length already reached: drop the byte and start a new stream
            produced_d = '0;
            flags_d    = '0;
            bits_d     = '0;
            phase_d    = PH_FLAG;
            th_d       = '0;
          end else begin
            unique case (phase_q)
              PH_FLAG: begin
                flags_d = in_byte_i;
                bits_d  = 4'(FLAG_BITS);
                phase_d = PH_ITEM;
              end
              PH_ITEM: begin
                flags_d = {flags_q[6:0], 1'b0};
                bits_d  = bits_q - 4'd1;
                if (flags_q[7]) begin
                  th_d    = in_byte_i;
                  phase_d = PH_TOKEN2;
                end else begin
                  lit_d   = in_byte_i;
                  state_d = S_LIT;
                end
              end
              PH_TOKEN2: begin
                cnt_d   = RUN_W'(th_q[7:4]) + RUN_W'(MATCH_BIAS);
                src_d   = ring_idx_q - back_w[RING_AW-1:0];
                state_d = S_RD;
              end
              default: begin
                phase_d = PH_FLAG;
              end
            endcase
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          emit_go = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_go   = 1'b1;
          emit_val  = hist_ok_q ? rd_data_q : 8'd0;
          emit_last = (cnt_q == RUN_W'(1)) || emit_done;
          cnt_d     = cnt_q - RUN_W'(1);
          src_d     = src_q + RING_AW'(1);
          state_d   = emit_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_go) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_val;
      run_last_d  = emit_last;
      done_d      = emit_done;
      ring_idx_d  = ring_idx_q + RING_AW'(1);
      if (ring_idx_q == '1) begin
        wrapped_d = 1'b1;
      end
      produced_d = cnt_next;
      if (emit_done) begin
        produced_d = '0;
        flags_d    = '0;
        bits_d     = '0;
        phase_d    = PH_FLAG;
        th_d       = '0;
      end else if (emit_last) begin
        phase_d = (bits_q == 4'd0) ? PH_FLAG : PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FLAG;
      flags_q     <= '0;
      bits_q      <= '0;
      th_q        <= '0;
      cnt_q       <= '0;
      ring_idx_q  <= '0;
      wrapped_q   <= 1'b0;
      produced_q  <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      bits_q      <= bits_d;
      th_q        <= th_d;
      cnt_q       <= cnt_d;
      ring_idx_q  <= ring_idx_d;
      wrapped_q   <= wrapped_d;
      produced_q  <= produced_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lit_q      <= lit_d;
    src_q      <= src_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
  end

  // History ring: one write at the write index, one registered read at the copy source
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      ring_mem[ring_idx_q] <= emit_val;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[src_q];
      // Entries at or past the write index read as zero until the ring has wrapped once
      hist_ok_q <= wrapped_q || (src_q < ring_idx_q);
    end
  end

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_EMIT) |-> (cnt_q != '0))
    else $error("copy sequencer active with empty run count");

  a_item_has_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && phase_q == PH_ITEM) |-> (bits_q != 4'd0))
    else $error("parser awaits an item with no flag bits left");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!done_res_o || run_last_o))
    else $error("done flagged on a result that is not the last of its item");

  a_done_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && emit_done) |=> (produced_q == '0 && phase_q == PH_FLAG))
    else $error("stream not restarted after reaching the output length");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the LZSS ring decompressor.
module tb_top;
  import lzrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned STREAM_CAP    = 60;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_RUN       = 18;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       done_res;
  } result_t;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_byte_o;
  logic             run_last_o;
  logic             done_res_o;

  lzss_ring_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .done_res_o  (done_res_o)
  );

  // Decoder state kept alongside the block
  logic [7:0]         hist_ring [RING_DEPTH];
  logic [RING_AW-1:0] hist_wr_idx;
  logic [LEN_W-1:0]   stream_count;
  logic [LEN_W-1:0]   stream_len;
  logic [7:0]         flag_reg;
  logic [3:0]         flags_left;
  phase_e             parse_ph;
  logic [7:0]         token_hi;
  bit                 stream_over;

  result_t     expected_bytes[$];
  int unsigned parsed_items;
  int unsigned errors;
  int unsigned cycle_count;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Compare each accepted result with the oldest expectation, then pick the next stall.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual byte %02h last %0b done %0b",
                 $time, out_byte_o, run_last_o, done_res_o);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $display("%0t out_byte mismatch: expected %02h actual %02h",
                   $time, want.out_byte, out_byte_o);
          errors++;
        end
        if (run_last_o !== want.run_last) begin
          $display("%0t run_last mismatch: expected %0b actual %0b",
                   $time, want.run_last, run_last_o);
          errors++;
        end
        if (done_res_o !== want.done_res) begin
          $display("%0t done_res mismatch: expected %0b actual %0b",
                   $time, want.done_res, done_res_o);
          errors++;
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 12);
  end

  task automatic open_stream();
    stream_count = '0;
    flag_reg     = '0;
    flags_left   = '0;
    parse_ph     = PH_FLAG;
    token_hi     = '0;
  endtask

  task automatic clear_decoder();
    for (int i = 0; i < RING_DEPTH; i++) hist_ring[i] = '0;
    hist_wr_idx = '0;
    stream_len  = '0;
    open_stream();
  endtask

  // Store one output byte in the ring; returns 1 once the stream length is reached.
  function automatic bit store_byte(input logic [7:0] v);
    hist_ring[hist_wr_idx] = v;
    hist_wr_idx = RING_AW'((hist_wr_idx + 1) % RING_DEPTH);
    stream_count++;
    return stream_count >= stream_len;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0]         run_buf [MAX_RUN];
    int                 n;
    bit                 hit_end;
    bit                 is_token;
    logic [4:0]         run;
    logic [12:0]        tok_dist;
    logic [RING_AW-1:0] back;
    logic [RING_AW-1:0] src;
    n = 0;
    hit_end = 1'b0;
    if (stream_count >= stream_len) begin
      // drop the item and restart the parser
      open_stream();
      stream_over = 1'b1;
    end else begin
      parsed_items++;
      case (parse_ph)
        PH_FLAG: begin
          flag_reg   = b;
          flags_left = 4'(FLAG_BITS);
          parse_ph   = PH_ITEM;
        end
        PH_ITEM: begin
          is_token   = flag_reg[7];
          flag_reg   = {flag_reg[6:0], 1'b0};
          flags_left = flags_left - 4'd1;
          if (is_token) begin
            token_hi = b;
            parse_ph = PH_TOKEN2;
          end else begin
            run_buf[0] = b;
            hit_end = store_byte(b);
            n = 1;
          end
        end
        default: begin
          run      = 5'(token_hi[7:4]) + 5'(MATCH_BIAS);
          tok_dist = 13'({token_hi[3:0], b}) + 13'(MATCH_BIAS);
          back     = RING_AW'(tok_dist % RING_DEPTH);
          for (int j = 0; j < run && !hit_end; j++) begin
            src = RING_AW'((hist_wr_idx + RING_DEPTH - back) % RING_DEPTH);
            run_buf[n] = hist_ring[src];
            hit_end = store_byte(run_buf[n]);
            n++;
          end
        end
      endcase
      if (n > 0) begin
        parse_ph = (flags_left == 4'd0) ? PH_FLAG : PH_ITEM;
        for (int i = 0; i < n; i++) begin
          expected_bytes.push_back('{out_byte: run_buf[i],
                                     run_last: (i == n - 1),
                                     done_res: (i == n - 1) && hit_end});
        end
        if (hit_end) begin
          open_stream();
          stream_over = 1'b1;
        end
      end
    end
  endtask

  // Hold valid and the byte until the block takes the item.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b);
  endtask

  // Write the length only once the block has drained.
  task automatic set_length(input logic [LEN_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    stream_len  = v;
    stream_over = 1'b0;
  endtask

  task automatic test_zero_length_after_reset();
    send_byte(8'h3C);
  endtask

  // Four literals, then short, overlapping and far tokens at the distance extremes.
  task automatic test_literals_and_tokens();
    set_length(32'd1000);
    send_byte(8'h0F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hF0); send_byte(8'h00);
    send_byte(8'h0F); send_byte(8'hFD);
    send_byte(8'hFF); send_byte(8'hFF);
  endtask

  task automatic test_cut_run();
    set_length(stream_count + 32'd5);
    send_byte(8'h80);
    send_byte(8'hF0);
    send_byte(8'h00);
  endtask

  task automatic test_lowered_length();
    set_length(32'd100);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h34);
    set_length(32'd1);
    send_byte(8'h77);
    send_byte(8'h00);
    send_byte(8'hC3);
    set_length(32'd0);
    send_byte(8'hA5);
  endtask

  // Bias toward tokens with long runs and short distances.
  function automatic logic [7:0] pick_byte(input bit noisy);
    logic [7:0] v;
    v = 8'($urandom);
    if (!noisy) begin
      case (parse_ph)
        PH_FLAG: if ($urandom_range(99) < 60) v = 8'hFF;
                 else v = v | 8'($urandom);
        PH_ITEM: if (flag_reg[7]) begin
          if ($urandom_range(99) < 60) v[7:4] = 4'hF;
          if ($urandom_range(99) < 75) v[3:0] = 4'h0;
        end
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic test_random_streams();
    int unsigned stream_no;
    int unsigned sent;
    int unsigned r;
    bit          noisy;
    logic [LEN_W-1:0] len;
    int unsigned target;
    target = parsed_items + RANDOM_ITEMS;
    stream_no = 0;
    while (parsed_items < target) begin
      r = $urandom_range(99);
      if (r < 5)       len = '0;
      else if (r < 10) len = 32'd1;
      else if (r < 15) len = '1;
      else if (r < 20) len = LEN_W'($urandom);
      else             len = LEN_W'($urandom_range(2, 600));
      set_length(len);
      calm  = (stream_no >= 3 && stream_no <= 6);
      noisy = ($urandom_range(99) < 15);
      sent  = 0;
      while (!stream_over && sent < STREAM_CAP) begin
        send_byte(pick_byte(noisy));
        sent++;
      end
      stream_no++;
    end
    calm = 1'b0;
  endtask

  initial begin
    errors        = 0;
    parsed_items  = 0;
    cycle_count   = 0;
    calm          = 1'b0;
    stream_over   = 1'b0;
    clear_decoder();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_length_after_reset();
    test_literals_and_tokens();
    test_cut_run();
    test_lowered_length();
    test_random_streams();

    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
